>>> hw/rtl/blr_pkg.sv
// blr_pkg: shared codes and reset constants for the line rasterizer
// no dependencies; imported by blr_cfg_regs and the rasterizer core

package blr_pkg;

    typedef enum logic
    {
        KIND_START = 1'b0,
        KIND_NEXT  = 1'b1
    } kind_t;

    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1
    } cfg_index_t;

    localparam int RESET_SCREEN_WIDTH  = 320;
    localparam int RESET_SCREEN_HEIGHT = 240;

endpackage

>>> hw/rtl/blr_cfg_regs.sv
// blr_cfg_regs: screen size registers written through the config channel
// depends on blr_pkg

module blr_cfg_regs #(
    parameter int SIZE_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [blr_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [SIZE_BITS-1:0]               wr_data,
    output logic [SIZE_BITS-1:0]               screen_width,
    output logic [SIZE_BITS-1:0]               screen_height
);
    import blr_pkg::*;

    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_BITS'(RESET_SCREEN_WIDTH);
            height_reg <= SIZE_BITS'(RESET_SCREEN_HEIGHT);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_SCREEN_WIDTH:  width_reg  <= wr_data;
                CFG_SCREEN_HEIGHT: height_reg <= wr_data;
                default:           ;
            endcase
        end
    end

    assign screen_width  = width_reg;
    assign screen_height = height_reg;

endmodule

>>> hw/rtl/blr_line_setup.sv
// blr_line_setup: endpoint range check and delta setup for a start item
// combinational; no package dependency

module blr_line_setup #(
    parameter int COORD_BITS = 11
) (
    input  logic signed [COORD_BITS:0]   start_x,
    input  logic signed [COORD_BITS:0]   start_y,
    input  logic signed [COORD_BITS:0]   end_x,
    input  logic signed [COORD_BITS:0]   end_y,
    input  logic        [COORD_BITS:0]   screen_width,
    input  logic        [COORD_BITS:0]   screen_height,
    output logic                         on_screen,
    output logic                         x_decreasing,
    output logic                         y_decreasing,
    output logic                         x_major,
    output logic        [COORD_BITS-1:0] major_delta,
    output logic        [COORD_BITS-1:0] minor_delta,
    output logic signed [COORD_BITS:0]   err_init
);
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic        [COORD_BITS:0]   dx_neg;
    logic        [COORD_BITS:0]   dy_neg;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;

    always_comb
    begin
        on_screen = !start_x[COORD_BITS] && ({1'b0, start_x[COORD_BITS-1:0]} < screen_width)
                 && !start_y[COORD_BITS] && ({1'b0, start_y[COORD_BITS-1:0]} < screen_height)
                 && !end_x[COORD_BITS]   && ({1'b0, end_x[COORD_BITS-1:0]}   < screen_width)
                 && !end_y[COORD_BITS]   && ({1'b0, end_y[COORD_BITS-1:0]}   < screen_height);

        dx     = end_x - start_x;
        dy     = end_y - start_y;
        dx_neg = -dx;
        dy_neg = -dy;
        x_decreasing = dx[COORD_BITS];
        y_decreasing = dy[COORD_BITS];
        adx = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

        x_major     = adx > ady;
        major_delta = x_major ? adx : ady;
        minor_delta = x_major ? ady : adx;
        err_init    = {2'b00, major_delta[COORD_BITS-1:1]};
    end

endmodule

>>> hw/rtl/blr_line_step.sv
// blr_line_step: one bresenham step from the current pixel to the next
// combinational; no package dependency

module blr_line_step #(
    parameter int COORD_BITS = 11
) (
    input  logic        [COORD_BITS-1:0] pos_x,
    input  logic        [COORD_BITS-1:0] pos_y,
    input  logic                         x_decreasing,
    input  logic                         y_decreasing,
    input  logic                         x_major,
    input  logic        [COORD_BITS-1:0] major_delta,
    input  logic        [COORD_BITS-1:0] minor_delta,
    input  logic signed [COORD_BITS:0]   err,
    output logic        [COORD_BITS-1:0] pos_x_next,
    output logic        [COORD_BITS-1:0] pos_y_next,
    output logic signed [COORD_BITS:0]   err_next
);
    logic signed [COORD_BITS:0]   err_sub;
    logic                         minor_step;
    logic        [COORD_BITS-1:0] x_moved;
    logic        [COORD_BITS-1:0] y_moved;

    always_comb
    begin
        err_sub    = err - $signed({1'b0, minor_delta});
        minor_step = err_sub[COORD_BITS];
        err_next   = minor_step ? err_sub + $signed({1'b0, major_delta}) : err_sub;

        x_moved = x_decreasing ? pos_x - 1'b1 : pos_x + 1'b1;
        y_moved = y_decreasing ? pos_y - 1'b1 : pos_y + 1'b1;

        pos_x_next = (x_major || minor_step) ? x_moved : pos_x;
        pos_y_next = (!x_major || minor_step) ? y_moved : pos_y;
    end

endmodule

>>> hw/rtl/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer. A start transfer (tuser 0) checks both endpoints
// against the screen size and, if both lie on screen, returns the first endpoint
// at once; each next transfer (tuser 1) returns one more pixel, with tlast on the
// second endpoint. Off-screen starts and next transfers while no line is active
// return nothing. One item is taken every cycle while the result side is not
// stalled; a result passes through the input register and then the result
// register, and the one-step update of the line state sets the single-cycle
// issue rate. Backpressure on the result side stalls the input side.
// blr_pkg, blr_cfg_regs, blr_line_setup, blr_line_step

module bresenham_line_rasterizer_core #(
    parameter int COORD_BITS = 11,
    parameter int COLOR_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_x, start_y, end_x, end_y, ink
    input  logic [((4 * (COORD_BITS + 1) + COLOR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // kind
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [blr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS:0]                cfg_data
);
    import blr_pkg::*;

    localparam int IN_BITS       = COORD_BITS + 1;
    localparam int IN_RAW_BITS   = 4 * IN_BITS + COLOR_BITS;
    localparam int OUT_RAW_BITS  = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    // input register
    logic                         in_valid_reg;
    logic                         in_valid_next;
    kind_t                        in_kind_reg;
    logic signed [COORD_BITS:0]   in_start_x_reg;
    logic signed [COORD_BITS:0]   in_start_y_reg;
    logic signed [COORD_BITS:0]   in_end_x_reg;
    logic signed [COORD_BITS:0]   in_end_y_reg;
    logic        [COLOR_BITS-1:0] in_ink_reg;

    // line state
    logic                         busy_reg;
    logic                         busy_next;
    logic        [COORD_BITS-1:0] pos_x_reg;
    logic        [COORD_BITS-1:0] pos_x_next;
    logic        [COORD_BITS-1:0] pos_y_reg;
    logic        [COORD_BITS-1:0] pos_y_next;
    logic                         x_dec_reg;
    logic                         y_dec_reg;
    logic                         x_major_reg;
    logic        [COORD_BITS-1:0] major_reg;
    logic        [COORD_BITS-1:0] minor_reg;
    logic signed [COORD_BITS:0]   err_reg;
    logic signed [COORD_BITS:0]   err_next;
    logic        [COORD_BITS-1:0] left_reg;
    logic        [COORD_BITS-1:0] left_next;
    logic        [COLOR_BITS-1:0] color_reg;

    // result register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic        [COORD_BITS-1:0] out_x_reg;
    logic        [COORD_BITS-1:0] out_y_reg;
    logic        [COLOR_BITS-1:0] out_color_reg;
    logic                         out_last_reg;
    logic                         out_last_next;

    logic                         in_xfer;
    logic                         advance;
    logic                         is_start;
    logic                         load_line;
    logic                         step_line;
    logic                         emit;

    logic        [COORD_BITS:0]   screen_width;
    logic        [COORD_BITS:0]   screen_height;

    logic                         setup_ok;
    logic                         setup_x_dec;
    logic                         setup_y_dec;
    logic                         setup_x_major;
    logic        [COORD_BITS-1:0] setup_major;
    logic        [COORD_BITS-1:0] setup_minor;
    logic signed [COORD_BITS:0]   setup_err;

    logic        [COORD_BITS-1:0] step_x;
    logic        [COORD_BITS-1:0] step_y;
    logic signed [COORD_BITS:0]   step_err;

    assign cfg_ready = 1'b1;

    blr_cfg_regs #(
        .SIZE_BITS (IN_BITS)
    ) u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (cfg_valid && cfg_ready),
        .wr_index      (cfg_index),
        .wr_data       (cfg_data),
        .screen_width  (screen_width),
        .screen_height (screen_height)
    );

    blr_line_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_line_setup (
        .start_x       (in_start_x_reg),
        .start_y       (in_start_y_reg),
        .end_x         (in_end_x_reg),
        .end_y         (in_end_y_reg),
        .screen_width  (screen_width),
        .screen_height (screen_height),
        .on_screen     (setup_ok),
        .x_decreasing  (setup_x_dec),
        .y_decreasing  (setup_y_dec),
        .x_major       (setup_x_major),
        .major_delta   (setup_major),
        .minor_delta   (setup_minor),
        .err_init      (setup_err)
    );

    blr_line_step #(
        .COORD_BITS (COORD_BITS)
    ) u_line_step (
        .pos_x        (pos_x_reg),
        .pos_y        (pos_y_reg),
        .x_decreasing (x_dec_reg),
        .y_decreasing (y_dec_reg),
        .x_major      (x_major_reg),
        .major_delta  (major_reg),
        .minor_delta  (minor_reg),
        .err          (err_reg),
        .pos_x_next   (step_x),
        .pos_y_next   (step_y),
        .err_next     (step_err)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        is_start  = (in_kind_reg == KIND_START);
        load_line = advance && is_start && setup_ok;
        step_line = advance && !is_start && busy_reg;
        emit      = load_line || step_line;

        left_next     = left_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        err_next      = err_reg;
        busy_next     = busy_reg;
        out_last_next = out_last_reg;

        if (load_line)
        begin
            left_next     = setup_major;
            pos_x_next    = in_start_x_reg[COORD_BITS-1:0];
            pos_y_next    = in_start_y_reg[COORD_BITS-1:0];
            err_next      = setup_err;
            out_last_next = (setup_major == '0);
            busy_next     = !out_last_next;
        end
        else if (step_line)
        begin
            left_next     = left_reg - 1'b1;
            pos_x_next    = step_x;
            pos_y_next    = step_y;
            err_next      = step_err;
            out_last_next = (left_next == '0);
            busy_next     = !out_last_next;
        end
        else if (advance && is_start)
        begin
            busy_next = 1'b0;
        end

        in_valid_next = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

        if (emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_kind_reg    <= kind_t'(s_axis_tuser);
            in_start_x_reg <= s_axis_tdata[IN_BITS-1:0];
            in_start_y_reg <= s_axis_tdata[2*IN_BITS-1:IN_BITS];
            in_end_x_reg   <= s_axis_tdata[3*IN_BITS-1:2*IN_BITS];
            in_end_y_reg   <= s_axis_tdata[4*IN_BITS-1:3*IN_BITS];
            in_ink_reg     <= s_axis_tdata[IN_RAW_BITS-1:4*IN_BITS];
        end

        if (load_line)
        begin
            x_dec_reg   <= setup_x_dec;
            y_dec_reg   <= setup_y_dec;
            x_major_reg <= setup_x_major;
            major_reg   <= setup_major;
            minor_reg   <= setup_minor;
            color_reg   <= in_ink_reg;
        end

        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        err_reg   <= err_next;
        left_reg  <= left_next;

        if (emit)
        begin
            out_x_reg     <= pos_x_next;
            out_y_reg     <= pos_y_next;
            out_color_reg <= load_line ? in_ink_reg : color_reg;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_color_reg, out_y_reg, out_x_reg});
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> hw/rtl/blr_checker.sv
// blr_checker: port-level assertions for the line rasterizer, bound to the top level
// depends on bresenham_line_rasterizer_core

module blr_checker #(
    parameter int OUT_DATA_BITS = 40
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic                     m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a new result must have been caused by an earlier input transfer
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a preceding input transfer");

    // with the result register empty the input side is never stalled
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // no result after a reset edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind bresenham_line_rasterizer_core blr_checker #(
    .OUT_DATA_BITS (OUT_DATA_BITS)
) u_blr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> test/tb_top.sv
// tb_top: self-checking testbench for bresenham_line_rasterizer_core, driving line
// requests and comparing every pixel against a cycle-free line predictor
// depends on blr_pkg and the rasterizer RTL

module tb_top;

    import blr_pkg::*;

    localparam int IN_DATA_BITS   = 64;
    localparam int OUT_DATA_BITS  = 40;
    localparam int PHASE_COUNT    = 9;
    localparam int PHASE_ITEMS    = 77;
    localparam int HOLD_PHASE     = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int MAX_REPORTS    = 40;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NO_SUCH_REG = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [11:0] sx;
        logic [11:0] sy;
        logic [11:0] ex;
        logic [11:0] ey;
        logic [15:0] ink;
    } line_req_t;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [15:0] color;
        logic        last;
    } pixel_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic                      s_axis_tuser = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [11:0]               cfg_data = '0;

    line_req_t pending_items[$];
    pixel_t    expected_pixels[$];
    line_req_t in_flight;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycle_count = 0;

    int phase_w[PHASE_COUNT] = '{2048, 1, 0, 4095, 17, 320, 640, 2048, 100};
    int phase_h[PHASE_COUNT] = '{2048, 1, 240, 33, 2048, 240, 480, 5, 100};

    // line predictor state
    int          screen_w = RESET_SCREEN_WIDTH;
    int          screen_h = RESET_SCREEN_HEIGHT;
    logic        line_active = 1'b0;
    logic [10:0] cur_x = '0;
    logic [10:0] cur_y = '0;
    logic        x_dec = 1'b0;
    logic        y_dec = 1'b0;
    logic        x_is_major = 1'b0;
    int          major_d = 0;
    int          minor_d = 0;
    int          err_term = 0;
    logic [10:0] pixels_to_go = '0;
    logic [15:0] line_ink = '0;

    bresenham_line_rasterizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic on_screen(input int x, input int y);
        return x >= 0 && x < screen_w && y >= 0 && y < screen_h;
    endfunction

    task automatic rasterize(input line_req_t req);
        int x1;
        int y1;
        int x2;
        int y2;
        int dx;
        int dy;
        int adx;
        int ady;
        pixel_t px;
        if (req.kind == KIND_START)
        begin
            x1 = $signed(req.sx);
            y1 = $signed(req.sy);
            x2 = $signed(req.ex);
            y2 = $signed(req.ey);
            if (!on_screen(x1, y1) || !on_screen(x2, y2))
            begin
                line_active = 1'b0;
                return;
            end
            dx = x2 - x1;
            dy = y2 - y1;
            x_dec = dx < 0;
            y_dec = dy < 0;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            x_is_major = adx > ady;
            major_d = x_is_major ? adx : ady;
            minor_d = x_is_major ? ady : adx;
            err_term = major_d >> 1;
            cur_x = x1[10:0];
            cur_y = y1[10:0];
            line_ink = req.ink;
            pixels_to_go = major_d[10:0];
        end
        else
        begin
            if (!line_active)
                return;
            pixels_to_go = pixels_to_go - 11'd1;
        end
        px.x = cur_x;
        px.y = cur_y;
        px.color = line_ink;
        px.last = pixels_to_go == 0;
        expected_pixels.push_back(px);
        line_active = pixels_to_go != 0;
        if (line_active)
        begin
            // step along the line; a negative error takes a minor step first
            err_term = err_term - minor_d;
            if (err_term < 0)
            begin
                if (x_is_major)
                    cur_y = y_dec ? cur_y - 11'd1 : cur_y + 11'd1;
                else
                    cur_x = x_dec ? cur_x - 11'd1 : cur_x + 11'd1;
                err_term = err_term + major_d;
            end
            if (x_is_major)
                cur_x = x_dec ? cur_x - 11'd1 : cur_x + 11'd1;
            else
                cur_y = y_dec ? cur_y - 11'd1 : cur_y + 11'd1;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            if (mismatches < MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // input side: one transfer per handshake, fed from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                rasterize(in_flight);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_flight = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {in_flight.ink, in_flight.ey, in_flight.ex,
                                     in_flight.sy, in_flight.sx};
                    s_axis_tuser <= in_flight.kind;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: random stalls plus long holds on request
    always @(posedge clk)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $error("pixel with no expectation: x=%0d y=%0d",
                               m_axis_tdata[10:0], m_axis_tdata[21:11]);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", want.x, m_axis_tdata[10:0]);
                    check_field("pixel_y", want.y, m_axis_tdata[21:11]);
                    check_field("pixel_color", want.color, m_axis_tdata[37:22]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= $urandom_range(99) >= rx_stall_pct;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_start(input int sx, input int sy, input int ex, input int ey,
                              input int ink);
        line_req_t req;
        req.kind = KIND_START;
        req.sx = 12'(sx);
        req.sy = 12'(sy);
        req.ex = 12'(ex);
        req.ey = 12'(ey);
        req.ink = 16'(ink);
        pending_items.push_back(req);
    endtask

    // endpoints and ink carry junk on next transfers
    task automatic push_next();
        line_req_t req;
        req.kind = KIND_NEXT;
        req.sx = 12'($urandom_range(4095));
        req.sy = 12'($urandom_range(4095));
        req.ex = 12'($urandom_range(4095));
        req.ey = 12'($urandom_range(4095));
        req.ink = 16'($urandom_range(65535));
        pending_items.push_back(req);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [11:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH)
            screen_w = value;
        else if (idx == CFG_SCREEN_HEIGHT)
            screen_h = value;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_near(input int c, input int lim, input int reach);
        int v;
        v = c + int'($urandom_range(2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > lim - 1)
            v = lim - 1;
        return v;
    endfunction

    // counted is the number of items queued
    task automatic queue_line(output int counted);
        int xl;
        int yl;
        int x1;
        int y1;
        int x2;
        int y2;
        int reach;
        int n;
        int pick;
        int cut;
        counted = 0;
        xl = (screen_w > 2048) ? 2048 : screen_w;
        yl = (screen_h > 2048) ? 2048 : screen_h;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            push_start($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                       $urandom_range(4095), $urandom_range(65535));
            counted = 1;
        end
        else if (pick < 14)
        begin
            push_next();
            counted = 1;
        end
        else if (xl == 0 || yl == 0)
        begin
            push_start($urandom_range(4095), $urandom_range(40), $urandom_range(40),
                       $urandom_range(4095), $urandom_range(65535));
            n = $urandom_range(2);
            repeat (n) push_next();
            counted = 1 + n;
        end
        else
        begin
            x1 = $urandom_range(xl - 1);
            y1 = $urandom_range(yl - 1);
            reach = ($urandom_range(9) == 0) ? 90 : 10;
            x2 = pick_near(x1, xl, reach);
            y2 = pick_near(y1, yl, reach);
            n = (x2 > x1 ? x2 - x1 : x1 - x2);
            if ((y2 > y1 ? y2 - y1 : y1 - y2) > n)
                n = (y2 > y1 ? y2 - y1 : y1 - y2);
            if (pick < 20)
            begin
                // broken sequence: one endpoint pushed off screen
                if ($urandom_range(1))
                    x2 = ($urandom_range(1) && xl < 2048) ? xl : -1 - int'($urandom_range(5));
                else
                    y2 = ($urandom_range(1) && yl < 2048) ? yl : -1 - int'($urandom_range(5));
            end
            else
            begin
                cut = $urandom_range(99);
                if (cut < 12)
                    n = $urandom_range(n);
                else if (cut < 22)
                    n = n + 1 + $urandom_range(2);
            end
            push_start(x1, y1, x2, y2, $urandom_range(65535));
            repeat (n) push_next();
            counted = 1 + n;
        end
    endtask

    initial
    begin
        int p;
        int done;
        int got;
        tx_idle_pct = 15;
        rx_stall_pct = 82;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed lines at the reset screen size
        push_next();
        push_start(-2048, 2047, 0, 0, 16'h1234);
        push_start(0, 0, 0, 0, 16'hFFFF);
        push_start(319, 239, 319, 239, 16'h0000);
        push_start(320, 0, 0, 0, 16'h1111);
        push_start(0, 0, 0, 240, 16'h2222);
        push_start(0, 0, 5, 2, 16'hA5A5);
        repeat (5) push_next();
        push_start(10, 10, 7, 17, 16'h5A5A);
        repeat (3) push_next();
        // restart mid-line with a diagonal, then one next past its end
        push_start(3, 3, 0, 0, 16'h0F0F);
        repeat (4) push_next();
        push_start(100, 50, 90, 50, 16'hF0F0);
        repeat (2) push_next();
        push_start(2047, 0, 0, 0, 16'h3333);
        push_next();
        wait_drained();

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            if (p < 3)
            begin
                tx_idle_pct = 15;
                rx_stall_pct = 82;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 82;
                rx_stall_pct = 15;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            write_reg(CFG_SCREEN_WIDTH, 12'(phase_w[p]));
            write_reg(CFG_SCREEN_HEIGHT, 12'(phase_h[p]));
            if (p == 2)
                write_reg(CFG_NO_SUCH_REG, 12'hABC);
            done = 0;
            if (p == HOLD_PHASE)
            begin
                // long line while the result side holds off
                push_start(0, 0, 200, 31, 16'hC3C3);
                repeat (200) push_next();
                hold_requests++;
                done = 201;
            end
            while (done < PHASE_ITEMS)
            begin
                queue_line(got);
                done += got;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
